### src/stis_pkg.sv
// Shared types and constants for the sorted table insert/search block.
// No dependencies; compile first.
package stis_pkg;

   localparam int CAPACITY = 256;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam int KEY_W    = 31;
   localparam int HANDLE_W = 16;
   localparam int STATUS_W = 2;
   localparam int ECOUNT_W = 9;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_SEARCH = 1'b1;

   localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

   typedef struct packed {
      logic [KEY_W-1:0]    key;
      logic [HANDLE_W-1:0] handle;
   } entry_type;

endpackage

### src/stis_channel_if.sv
// Valid/ready channel interfaces for request and response transactions.
// Depends on stis_pkg.
interface stis_req_if
   import stis_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic                kind;
   logic [KEY_W-1:0]    key;
   logic [HANDLE_W-1:0] handle;

   modport source (output valid, output kind, output key, output handle, input ready);
   modport sink   (input valid, input kind, input key, input handle, output ready);
endinterface

interface stis_rsp_if
   import stis_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [HANDLE_W-1:0] found_handle;
   logic [ECOUNT_W-1:0] entry_count;

   modport source (output valid, output status, output found_handle, output entry_count,
                   input ready);
   modport sink   (input valid, input status, input found_handle, input entry_count,
                   output ready);
endinterface

### src/sorted_table_insert_search.sv
// Top level of the sorted table: sequencer, entry memory and response register.
// Depends on stis_pkg and the channel interfaces in stis_channel_if.sv.
//
//  - req_chan carries one transaction per item: kind (insert or search), key,
//    and handle (insert only). rsp_chan returns exactly one transaction per
//    item: status, found_handle and entry_count, in request order.
//  - Entries live in one 256 x 47-bit memory (key, handle) with a registered
//    read port; every table access goes through it.
//  - Insert: entries above the new key move up one slot per cycle, top down
//    (read of the next slot overlaps the write of the last); between 0 and
//    count entries move. A full table goes straight to S_HOLD with ST_FULL.
//  - Search: each probe addresses the midpoint (S_PROBE), then compares on the
//    read data (S_CMP); a hit ends the search. At most 9 probes on 256 entries.
//  - One item in work at a time: req_chan.ready is high while the sequencer is
//    idle, also while a response still waits on rsp_chan.
//  - Receiver stall: the next result is parked until the response register
//    frees up; no result is dropped or repeated.
//  - Reset (synchronous, active high) empties the table and clears response
//    valid. Memory is not cleared: only data from slots below the entry count is used.
module sorted_table_insert_search
   import stis_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   stis_req_if.sink   req_chan,
   stis_rsp_if.source rsp_chan
);

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_INS   = 3'd1;  // compare slot pos-1, shift or place
   localparam logic [2:0] S_PROBE = 3'd2;  // issue midpoint read
   localparam logic [2:0] S_CMP   = 3'd3;  // compare midpoint key
   localparam logic [2:0] S_HOLD  = 3'd4;  // hand result to response register

   logic [2:0]          state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic [CNT_W-1:0]    pos_ff, pos_in;     // slot the next write lands in
   logic [CNT_W-1:0]    lo_ff, lo_in;       // search window [lo, hix)
   logic [CNT_W-1:0]    hix_ff, hix_in;
   logic [CNT_W-1:0]    mid_ff, mid_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [HANDLE_W-1:0] res_handle_ff, res_handle_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [HANDLE_W-1:0] rsp_handle_ff, rsp_handle_in;
   logic [ECOUNT_W-1:0] rsp_count_ff, rsp_count_in;

   // entry memory
   entry_type        mem [CAPACITY];
   entry_type        rd_data_ff;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;

   logic [CNT_W:0]   win_sum;
   logic [CNT_W-1:0] mid;
   logic [CNT_W-1:0] pos_m1;
   logic [CNT_W-1:0] pos_m2;
   logic [CNT_W-1:0] cnt_m1;
   logic             do_shift;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // floor((lo + hi) / 2) with hi = hix - 1; only used while lo < hix
   assign win_sum  = {1'b0, lo_ff} + {1'b0, hix_ff} - (CNT_W + 1)'(1);
   assign mid      = win_sum[CNT_W:1];
   assign pos_m1   = pos_ff - CNT_W'(1);
   assign pos_m2   = pos_ff - CNT_W'(2);
   assign cnt_m1   = count_ff - CNT_W'(1);
   // strictly greater keys move up; equal keys stay below the new entry
   assign do_shift = (pos_ff != '0) && (key_ff < rd_data_ff.key);

   assign req_chan.ready        = (state_ff == S_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.found_handle = rsp_handle_ff;
   assign rsp_chan.entry_count  = rsp_count_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      key_in        = key_ff;
      handle_in     = handle_ff;
      pos_in        = pos_ff;
      lo_in         = lo_ff;
      hix_in        = hix_ff;
      mid_in        = mid_ff;
      res_status_in = res_status_ff;
      res_handle_in = res_handle_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_count_in  = rsp_count_ff;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = pos_ff[IDX_W-1:0];
      wr_data       = '{key: key_ff, handle: handle_ff};

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               key_in    = req_chan.key;
               handle_in = req_chan.handle;
               if (req_chan.kind == KIND_SEARCH) begin
                  lo_in    = '0;
                  hix_in   = count_ff;
                  state_in = S_PROBE;
               end else if (count_ff == CNT_W'(CAPACITY)) begin
                  res_status_in = ST_FULL;
                  res_handle_in = '0;
                  state_in      = S_HOLD;
               end else begin
                  // top entry read; empty table goes straight to placement
                  rd_addr  = cnt_m1[IDX_W-1:0];
                  pos_in   = count_ff;
                  state_in = S_INS;
               end
            end
         end
         S_INS: begin
            wr_en = 1'b1;
            if (do_shift) begin
               wr_data  = rd_data_ff;
               rd_addr  = pos_m2[IDX_W-1:0];
               pos_in   = pos_m1;
            end else begin
               count_in      = count_ff + CNT_W'(1);
               res_status_in = ST_INSERTED;
               res_handle_in = '0;
               state_in      = S_HOLD;
            end
         end
         S_PROBE: begin
            if (lo_ff < hix_ff) begin
               rd_addr  = mid[IDX_W-1:0];
               mid_in   = mid;
               state_in = S_CMP;
            end else begin
               res_status_in = ST_NOT_FOUND;
               res_handle_in = '0;
               state_in      = S_HOLD;
            end
         end
         S_CMP: begin
            if (key_ff == rd_data_ff.key) begin
               res_status_in = ST_FOUND;
               res_handle_in = rd_data_ff.handle;
               state_in      = S_HOLD;
            end else begin
               if (key_ff < rd_data_ff.key) begin
                  hix_in = mid_ff;
               end else begin
                  lo_in = mid_ff + CNT_W'(1);
               end
               state_in = S_PROBE;
            end
         end
         S_HOLD: begin
            // count already reflects this item here
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_handle_in = res_handle_ff;
               rsp_count_in  = count_ff[ECOUNT_W-1:0];
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff        <= key_in;
      handle_ff     <= handle_in;
      pos_ff        <= pos_in;
      lo_ff         <= lo_in;
      hix_ff        <= hix_in;
      mid_ff        <= mid_in;
      res_status_ff <= res_status_in;
      res_handle_ff <= res_handle_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_count_ff  <= rsp_count_in;
   end

endmodule
